### rtl/core/box_average_image_downscaler_top_macros.svh
// assertion macros used by the checker file of the downscaler
`ifndef BOX_AVERAGE_IMAGE_DOWNSCALER_TOP_MACROS_SVH
`define BOX_AVERAGE_IMAGE_DOWNSCALER_TOP_MACROS_SVH

// checked property, quiet while reset is asserted
`define BAVG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked property that also covers the reset period
`define BAVG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/bavg_pkg.sv
// shared types, constants and the reciprocal table of the box average downscaler
`default_nettype none

package bavg_pkg;

  // storage geometry
  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned MAX_FACTOR  = 16;
  localparam int unsigned LANES       = 4;
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned ADDR_W      = $clog2(MAX_WIDTH);
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned ROW_W       = LANES * SUM_W;

  // register widths
  localparam int unsigned FACTOR_W    = 5;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned CHAN_W      = 3;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_IDX_W   = 2;

  // register reset values
  localparam logic [FACTOR_W-1:0] FACTOR_RST = 5'd2;
  localparam logic [DIM_W-1:0]    WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 13'd480;
  localparam logic [CHAN_W-1:0]   CHAN_RST   = 3'd3;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W  = FIFO_PTR_W + 1;

  // reciprocal of the block area, scaled by 2^RECIP_SHIFT and rounded up
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_CHANS  = 2'd3
  } cfg_idx_e;

  // clamped configuration as the datapath uses it
  typedef struct packed {
    logic [FACTOR_W-1:0] n;
    logic [DIM_W-1:0]    w;
    logic [DIM_W-1:0]    h;
    logic [CHAN_W-1:0]   chans;
  } cfg_t;

  // one classified pixel handed from front to back
  typedef struct packed {
    logic [ADDR_W-1:0]                  col;
    logic [ADDR_W-1:0]                  row;
    logic                               fresh;
    logic                               emit;
    logic                               last;
    logic [LANES-1:0][SAMPLE_W-1:0]     samp;
  } entry_t;

  // ceil(2^24 / n^2); exact truncated quotient for every block sum
  function automatic logic [RECIP_W-1:0] recip_of(input logic [FACTOR_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      5'd1:    r = 25'd16777216;
      5'd2:    r = 25'd4194304;
      5'd3:    r = 25'd1864136;
      5'd4:    r = 25'd1048576;
      5'd5:    r = 25'd671089;
      5'd6:    r = 25'd466034;
      5'd7:    r = 25'd342393;
      5'd8:    r = 25'd262144;
      5'd9:    r = 25'd207127;
      5'd10:   r = 25'd167773;
      5'd11:   r = 25'd138655;
      5'd12:   r = 25'd116509;
      5'd13:   r = 25'd99274;
      5'd14:   r = 25'd85599;
      5'd15:   r = 25'd74566;
      5'd16:   r = 25'd65536;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/box_average_image_downscaler_top.sv
// Box average downscaler: takes one raster pixel word per clock and emits the
// truncated mean of each n-by-n block when its bottom-right pixel arrives.
// Sustained rate is one pixel per clock; the front only stalls when the
// four-word queue in front of the accumulator is full, which happens only
// while the output is held. Each word passes the queue, the accumulate stage,
// the scale stage and the output register. Column sums live in a 4096 x 64
// bit ram (at most one write and one registered read per clock, none while
// the output is held); a pixel that hits the column written in the previous
// clock is served from a forwarding register. The sums are never cleared:
// the first pixel of a block overwrites its column. Register writes restart
// the frame position and must only be issued while the block is idle.
`default_nettype none

module box_average_image_downscaler_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bavg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bavg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [7:0]                      sample_ch0_i,
  input  wire logic [7:0]                      sample_ch1_i,
  input  wire logic [7:0]                      sample_ch2_i,
  input  wire logic [7:0]                      sample_ch3_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [7:0]                           avg_ch0_o,
  output logic [7:0]                           avg_ch1_o,
  output logic [7:0]                           avg_ch2_o,
  output logic [7:0]                           avg_ch3_o,
  output logic [11:0]                          out_column_o,
  output logic [11:0]                          out_row_o,
  output logic                                 frame_done_o
);

  localparam int unsigned FW = bavg_pkg::FACTOR_W;
  localparam int unsigned DW = bavg_pkg::DIM_W;
  localparam int unsigned CW = bavg_pkg::CHAN_W;

  logic [FW-1:0]   scale_q;
  logic [DW-1:0]   width_q, height_q;
  logic [CW-1:0]   chans_q;
  bavg_pkg::cfg_t  cfg;
  logic            fifo_push, fifo_full, fifo_pop, fifo_empty;
  bavg_pkg::entry_t push_ent, head_ent;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= bavg_pkg::FACTOR_RST;
      width_q  <= bavg_pkg::WIDTH_RST;
      height_q <= bavg_pkg::HEIGHT_RST;
      chans_q  <= bavg_pkg::CHAN_RST;
    end else if (cfg_we_i) begin
      case (bavg_pkg::cfg_idx_e'(cfg_idx_i))
        bavg_pkg::CFG_SCALE:  scale_q  <= cfg_data_i[FW-1:0];
        bavg_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[DW-1:0];
        bavg_pkg::CFG_HEIGHT: height_q <= cfg_data_i[DW-1:0];
        bavg_pkg::CFG_CHANS:  chans_q  <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, large values saturate
  always_comb begin
    cfg.n     = (scale_q == '0) ? FW'(1) :
                (scale_q > FW'(bavg_pkg::MAX_FACTOR)) ? FW'(bavg_pkg::MAX_FACTOR) : scale_q;
    cfg.w     = (width_q == '0) ? DW'(1) :
                (width_q > DW'(bavg_pkg::MAX_WIDTH)) ? DW'(bavg_pkg::MAX_WIDTH) : width_q;
    cfg.h     = (height_q == '0) ? DW'(1) :
                (height_q > DW'(bavg_pkg::MAX_HEIGHT)) ? DW'(bavg_pkg::MAX_HEIGHT) : height_q;
    cfg.chans = (chans_q == '0) ? CW'(1) :
                (chans_q > CW'(bavg_pkg::LANES)) ? CW'(bavg_pkg::LANES) : chans_q;
  end

  bavg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .restart_i    (cfg_we_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_ch0_i (sample_ch0_i),
    .sample_ch1_i (sample_ch1_i),
    .sample_ch2_i (sample_ch2_i),
    .sample_ch3_i (sample_ch3_i),
    .full_i       (fifo_full),
    .push_o       (fifo_push),
    .entry_o      (push_ent)
  );

  bavg_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (push_ent),
    .full_o      (fifo_full),
    .pop_i       (fifo_pop),
    .head_o      (head_ent),
    .empty_o     (fifo_empty)
  );

  bavg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .factor_i     (cfg.n),
    .head_i       (head_ent),
    .empty_i      (fifo_empty),
    .pop_o        (fifo_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .avg_ch0_o    (avg_ch0_o),
    .avg_ch1_o    (avg_ch1_o),
    .avg_ch2_o    (avg_ch2_o),
    .avg_ch3_o    (avg_ch3_o),
    .out_column_o (out_column_o),
    .out_row_o    (out_row_o),
    .frame_done_o (frame_done_o)
  );

endmodule

`default_nettype wire

### rtl/core/bavg_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module bavg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/bavg_fifo.sv
// short word queue between the classifying front and the accumulating back
`default_nettype none

module bavg_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire bavg_pkg::entry_t push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output bavg_pkg::entry_t      head_o,
  output logic                  empty_o
);

  bavg_pkg::entry_t                      mem_q [bavg_pkg::FIFO_DEPTH];
  logic [bavg_pkg::FIFO_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [bavg_pkg::FIFO_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [bavg_pkg::FIFO_CNT_W-1:0]       cnt_q, cnt_d;
  logic                                  do_push, do_pop;

  localparam logic [bavg_pkg::FIFO_PTR_W-1:0] PtrLast =
    bavg_pkg::FIFO_PTR_W'(bavg_pkg::FIFO_DEPTH - 1);
  localparam logic [bavg_pkg::FIFO_CNT_W-1:0] CntFull =
    bavg_pkg::FIFO_CNT_W'(bavg_pkg::FIFO_DEPTH);

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bavg_front.sv
// raster position tracking and pixel classification
`default_nettype none

module bavg_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire bavg_pkg::cfg_t          cfg_i,
  input  wire logic                    restart_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [bavg_pkg::SAMPLE_W-1:0] sample_ch0_i,
  input  wire logic [bavg_pkg::SAMPLE_W-1:0] sample_ch1_i,
  input  wire logic [bavg_pkg::SAMPLE_W-1:0] sample_ch2_i,
  input  wire logic [bavg_pkg::SAMPLE_W-1:0] sample_ch3_i,
  input  wire logic                    full_i,
  output logic                         push_o,
  output bavg_pkg::entry_t             entry_o
);

  localparam int unsigned AW = bavg_pkg::ADDR_W;
  localparam int unsigned FW = bavg_pkg::FACTOR_W;
  localparam int unsigned DW = bavg_pkg::DIM_W;
  localparam int unsigned CW = DW + 1;

  logic [AW-1:0]   col_q, col_d, row_q, row_d;
  logic [AW-1:0]   bcol_q, bcol_d, brow_q, brow_d;
  logic [FW-2:0]   cib_q, cib_d, rib_q, rib_d;

  logic            accept;
  logic [AW-1:0]   col_start, row_start;
  logic            col_fit, row_fit, col_last, row_last;
  logic [FW-1:0]   cib_inc, rib_inc, n_m1;
  logic [DW-1:0]   col_inc, row_inc;
  logic [bavg_pkg::LANES-1:0][bavg_pkg::SAMPLE_W-1:0] raw;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // block placement of the current pixel
  assign n_m1      = cfg_i.n - 1'b1;
  assign col_start = col_q - AW'(cib_q);
  assign row_start = row_q - AW'(rib_q);
  assign col_fit   = (CW'(col_start) + CW'(cfg_i.n)) <= CW'(cfg_i.w);
  assign row_fit   = (CW'(row_start) + CW'(cfg_i.n)) <= CW'(cfg_i.h);
  assign col_last  = (CW'(col_start) + (CW'(cfg_i.n) << 1)) > CW'(cfg_i.w);
  assign row_last  = (CW'(row_start) + (CW'(cfg_i.n) << 1)) > CW'(cfg_i.h);

  assign raw[0] = sample_ch0_i;
  assign raw[1] = sample_ch1_i;
  assign raw[2] = sample_ch2_i;
  assign raw[3] = sample_ch3_i;

  // classified word, unused channels forced to zero
  always_comb begin
    entry_o.col   = bcol_q;
    entry_o.row   = brow_q;
    entry_o.fresh = (cib_q == '0) && (rib_q == '0);
    entry_o.emit  = (FW'(cib_q) == n_m1) && (FW'(rib_q) == n_m1);
    entry_o.last  = col_last && row_last;
    for (int k = 0; k < bavg_pkg::LANES; k++) begin
      entry_o.samp[k] = (bavg_pkg::CHAN_W'(k) < cfg_i.chans) ? raw[k] : '0;
    end
  end

  assign push_o = accept && col_fit && row_fit;

  // raster advance
  assign cib_inc = FW'(cib_q) + 1'b1;
  assign rib_inc = FW'(rib_q) + 1'b1;
  assign col_inc = DW'(col_q) + 1'b1;
  assign row_inc = DW'(row_q) + 1'b1;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    bcol_d = bcol_q;
    brow_d = brow_q;
    cib_d  = cib_q;
    rib_d  = rib_q;
    if (restart_i) begin
      col_d  = '0;
      row_d  = '0;
      bcol_d = '0;
      brow_d = '0;
      cib_d  = '0;
      rib_d  = '0;
    end else if (accept) begin
      if (cib_inc >= cfg_i.n) begin
        cib_d  = '0;
        bcol_d = bcol_q + 1'b1;
      end else begin
        cib_d  = cib_inc[FW-2:0];
      end
      col_d = col_inc[AW-1:0];
      if (col_inc >= cfg_i.w) begin
        col_d  = '0;
        cib_d  = '0;
        bcol_d = '0;
        row_d  = row_inc[AW-1:0];
        if (rib_inc >= cfg_i.n) begin
          rib_d  = '0;
          brow_d = brow_q + 1'b1;
        end else begin
          rib_d  = rib_inc[FW-2:0];
        end
        if (row_inc >= cfg_i.h) begin
          row_d  = '0;
          rib_d  = '0;
          brow_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      bcol_q <= '0;
      brow_q <= '0;
      cib_q  <= '0;
      rib_q  <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      bcol_q <= bcol_d;
      brow_q <= brow_d;
      cib_q  <= cib_d;
      rib_q  <= rib_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bavg_back.sv
// column accumulation, area scaling and output register
`default_nettype none

module bavg_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [bavg_pkg::FACTOR_W-1:0] factor_i,
  input  wire bavg_pkg::entry_t              head_i,
  input  wire logic                          empty_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [bavg_pkg::SAMPLE_W-1:0]      avg_ch0_o,
  output logic [bavg_pkg::SAMPLE_W-1:0]      avg_ch1_o,
  output logic [bavg_pkg::SAMPLE_W-1:0]      avg_ch2_o,
  output logic [bavg_pkg::SAMPLE_W-1:0]      avg_ch3_o,
  output logic [bavg_pkg::ADDR_W-1:0]        out_column_o,
  output logic [bavg_pkg::ADDR_W-1:0]        out_row_o,
  output logic                               frame_done_o
);

  localparam int unsigned L  = bavg_pkg::LANES;
  localparam int unsigned SW = bavg_pkg::SUM_W;
  localparam int unsigned PW = bavg_pkg::PROD_W;
  localparam int unsigned RS = bavg_pkg::RECIP_SHIFT;

  logic                              en;

  // accumulate stage
  logic                              b_vld_q;
  bavg_pkg::entry_t                  b_ent_q;
  logic [bavg_pkg::ROW_W-1:0]        rd_data, old_row, new_row;

  // last store write, for read-after-write forwarding
  logic                              lw_vld_q;
  logic [bavg_pkg::ADDR_W-1:0]       lw_addr_q;
  logic [bavg_pkg::ROW_W-1:0]        lw_data_q;

  // scale stage
  logic                              c_vld_q;
  logic [L-1:0][SW-1:0]              c_sum_q;
  logic [bavg_pkg::ADDR_W-1:0]       c_col_q, c_row_q;
  logic                              c_last_q;
  logic [bavg_pkg::RECIP_W-1:0]      recip_q;
  logic [L-1:0][bavg_pkg::SAMPLE_W-1:0] avg_d;

  // output register
  logic                              o_vld_q;
  logic [L-1:0][bavg_pkg::SAMPLE_W-1:0] o_avg_q;
  logic [bavg_pkg::ADDR_W-1:0]       o_col_q, o_row_q;
  logic                              o_last_q;

  // whole pipe moves unless a finished word is held
  assign en    = !o_vld_q || !out_stall_i;
  assign pop_o = en && !empty_i;

  bavg_ram #(
    .Width (bavg_pkg::ROW_W),
    .Depth (bavg_pkg::MAX_WIDTH)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (en && b_vld_q),
    .waddr_i (b_ent_q.col),
    .wdata_i (new_row),
    .re_i    (en),
    .raddr_i (head_i.col),
    .rdata_o (rd_data)
  );

  // per-lane running sum, restarted at block start
  always_comb begin
    old_row = (lw_vld_q && (lw_addr_q == b_ent_q.col)) ? lw_data_q : rd_data;
    for (int k = 0; k < L; k++) begin
      new_row[k*SW +: SW] = b_ent_q.fresh ? SW'(b_ent_q.samp[k])
                                          : old_row[k*SW +: SW] + SW'(b_ent_q.samp[k]);
    end
  end

  // truncated mean by reciprocal multiply
  always_comb begin
    for (int k = 0; k < L; k++) begin
      logic [PW-1:0] prod;
      prod     = PW'(c_sum_q[k]) * PW'(recip_q);
      avg_d[k] = prod[RS +: bavg_pkg::SAMPLE_W];
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q  <= 1'b0;
      lw_vld_q <= 1'b0;
      c_vld_q  <= 1'b0;
      o_vld_q  <= 1'b0;
    end else if (en) begin
      b_vld_q <= !empty_i;
      if (b_vld_q) begin
        lw_vld_q <= 1'b1;
      end
      c_vld_q <= b_vld_q && b_ent_q.emit;
      o_vld_q <= c_vld_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    recip_q <= bavg_pkg::recip_of(factor_i);
    if (en) begin
      b_ent_q <= head_i;
      if (b_vld_q) begin
        lw_addr_q <= b_ent_q.col;
        lw_data_q <= new_row;
      end
      for (int k = 0; k < L; k++) begin
        c_sum_q[k] <= new_row[k*SW +: SW];
      end
      c_col_q  <= b_ent_q.col;
      c_row_q  <= b_ent_q.row;
      c_last_q <= b_ent_q.last;
      o_avg_q  <= avg_d;
      o_col_q  <= c_col_q;
      o_row_q  <= c_row_q;
      o_last_q <= c_last_q;
    end
  end

  assign out_valid_o  = o_vld_q;
  assign avg_ch0_o    = o_avg_q[0];
  assign avg_ch1_o    = o_avg_q[1];
  assign avg_ch2_o    = o_avg_q[2];
  assign avg_ch3_o    = o_avg_q[3];
  assign out_column_o = o_col_q;
  assign out_row_o    = o_row_q;
  assign frame_done_o = o_last_q;

endmodule

`default_nettype wire

### rtl/core/bavg_checker.sv
// port-level checks of the downscaler, bound to the top level
`default_nettype none
`include "box_average_image_downscaler_top_macros.svh"

module bavg_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bavg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bavg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_stall_o,
  input  wire logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  input  wire logic [7:0]                      avg_ch0_o,
  input  wire logic [7:0]                      avg_ch1_o,
  input  wire logic [7:0]                      avg_ch2_o,
  input  wire logic [7:0]                      avg_ch3_o,
  input  wire logic [11:0]                     out_column_o,
  input  wire logic [11:0]                     out_row_o,
  input  wire logic                            frame_done_o
);

  logic [bavg_pkg::CHAN_W-1:0] chan_q;

  // shadow of the channel count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= bavg_pkg::CHAN_RST;
    end else if (cfg_we_i && (cfg_idx_i == bavg_pkg::CFG_CHANS)) begin
      chan_q <= cfg_data_i[bavg_pkg::CHAN_W-1:0];
    end
  end

  // a held word stays offered
  `BAVG_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "output word dropped while stalled")

  // a held word keeps its payload
  `BAVG_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(avg_ch0_o) && $stable(avg_ch1_o) && $stable(avg_ch2_o) && $stable(avg_ch3_o) && $stable(out_column_o) && $stable(out_row_o) && $stable(frame_done_o), "output payload changed while stalled")

  // channels not in use read as zero
  `BAVG_ASSERT(a_unused_zero, out_valid_o |-> (avg_ch1_o == 8'd0 || chan_q >= 3'd2) && (avg_ch2_o == 8'd0 || chan_q >= 3'd3) && (avg_ch3_o == 8'd0 || chan_q >= 3'd4), "unused channel mean is not zero")

  // reset leaves no word pending and the queue open
  `BAVG_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o && !in_stall_o, "block not idle after reset")

endmodule

bind box_average_image_downscaler_top bavg_checker u_bavg_checker (.*);

`default_nettype wire
